/* design/lrpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lrpc_pkg;

  // Fixed field widths
  localparam int FRM_W      = 20;
  localparam int ELAPSED_W  = 32;
  localparam int FPS_W      = 10;
  localparam int LEND_W     = 21;
  localparam int FUNC_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int PROD_W     = ELAPSED_W + FPS_W;
  localparam int GAIN_W     = PROD_W + 1;
  localparam int SPAN_W     = FRM_W + 1;

  // Command codes
  localparam logic [FUNC_W-1:0] FN_TICK  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PLAY  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PAUSE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_STOP  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SCRUB = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FPS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_EN    = 3'd4;

  // Register reset values
  localparam logic [FPS_W-1:0]  FPS_RESET      = 10'd30;
  localparam logic [LEND_W-1:0] LOOP_END_RESET = 21'h1FFFFF;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [ELAPSED_W-1:0] elapsed;
    logic [FRM_W-1:0]     device_frames;
    logic [FRM_W-1:0]     target_frame;
  } in_req_t;

  typedef struct packed {
    logic [FRM_W-1:0] frame_now;
    logic             is_playing;
    logic             apply_frame;
    logic             changed;
  } out_req_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic sum;
    logic div_load;
    logic div_step;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic tick_run;
    logic need_div;
    logic out_free;
  } ctl_sts_t;

endpackage
`default_nettype wire

/* design/lrpc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module lrpc_ctrl #(
  parameter int DIV_STEPS = 21
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  lrpc_pkg::ctl_sts_t  sts,
  output lrpc_pkg::ctl_cmd_t  cmd
);
  import lrpc_pkg::*;

  localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SUM,
    S_CHK,
    S_DIV,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Take a request only when idle and out of reset
  assign in_stall = (state_r != S_IDLE) || !rst_n;

  // Sequence the datapath
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.tick_run) begin
          cmd.prep  = 1'b1;
          state_nxt = S_SUM;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = CNT_W'(DIV_STEPS - 1);
        state_nxt    = sts.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.prep, cmd.sum, cmd.div_load, cmd.div_step, cmd.commit}))
    else $error("more than one datapath command at once");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> in_stall)
    else $error("request accepted but controller did not leave idle");

  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && sts.need_div) |=> (state_r == S_DIV && cnt_r == CNT_W'(DIV_STEPS - 1)))
    else $error("wrap did not start the remainder sequence");

endmodule
`default_nettype wire

/* design/lrpc_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
module lrpc_dpath #(
  parameter int FRAME_BITS     = 20,
  parameter int TIME_FRAC_BITS = 24,
  parameter int DIV_W          = 21
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  lrpc_pkg::in_req_t                   in_data,
  input  wire                                 cfg_wr_en,
  input  wire  [lrpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [lrpc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output lrpc_pkg::out_req_t                  out_data,
  input  lrpc_pkg::ctl_cmd_t                  cmd,
  output lrpc_pkg::ctl_sts_t                  sts
);
  import lrpc_pkg::*;

  localparam int ADV_W = GAIN_W - TIME_FRAC_BITS;

  // Configuration registers
  logic [FPS_W-1:0]  fps_r;
  logic [FRM_W-1:0]  loop_start_r;
  logic [LEND_W-1:0] loop_end_r;
  logic [FRM_W-1:0]  fixed_len_r;
  logic              loop_en_r;

  // Playback state
  logic [FRAME_BITS-1:0]     frame_position_r, frame_position_nxt;
  logic                      running_r, running_nxt;
  logic [TIME_FRAC_BITS-1:0] frame_fraction_r, frame_fraction_nxt;

  // Work registers
  in_req_t                   req_r;
  logic [FRM_W-1:0]          start_r, end_r;
  logic [SPAN_W-1:0]         span_r;
  logic [FRAME_BITS-1:0]     snap_pos_r;
  logic [TIME_FRAC_BITS-1:0] snap_frac_r, new_frac_r;
  logic [PROD_W-1:0]         prod_r;
  logic [DIV_W-1:0]          next_r, dvd_r;
  logic                      over_r, adv_zero_r;
  logic [SPAN_W-1:0]         rem_r;

  // Output register
  logic     out_valid_r;
  out_req_t out_data_r, out_data_nxt;

  // Region and snap terms
  logic [FRM_W-1:0]      len_w, last_w, start_w, end_w, lend_w;
  logic [FPS_W-1:0]      fps_w;
  logic                  outside_w;
  logic [GAIN_W-1:0]     gain_w;
  logic [ADV_W-1:0]      adv_w;
  logic [DIV_W-1:0]      next_w;
  logic [SPAN_W:0]       shift_w;
  logic [DIV_W-1:0]      res_w;
  logic [FRM_W-1:0]      scrub_w;
  logic                  tick_run_w;

  assign tick_run_w = (req_r.func == FN_TICK) && running_r;

  // Resolve timeline length and clamp the loop region
  always_comb begin
    if (fixed_len_r != '0) begin
      len_w = fixed_len_r;
    end else if (req_r.device_frames != '0) begin
      len_w = req_r.device_frames;
    end else begin
      len_w = FRM_W'(1);
    end
    last_w  = len_w - FRM_W'(1);
    start_w = (loop_start_r < last_w) ? loop_start_r : last_w;
    lend_w  = loop_end_r[FRM_W-1:0];
    if (loop_end_r[LEND_W-1]) begin
      end_w = last_w;
    end else if (lend_w < start_w) begin
      end_w = start_w;
    end else if (lend_w > last_w) begin
      end_w = last_w;
    end else begin
      end_w = lend_w;
    end
    outside_w = (DIV_W'(frame_position_r) < DIV_W'(start_w)) ||
                (DIV_W'(frame_position_r) > DIV_W'(end_w));
    fps_w     = (fps_r != '0) ? fps_r : FPS_W'(1);
  end

  // Add the gained time and split whole frames from the fraction
  assign gain_w = GAIN_W'(prod_r) + GAIN_W'(snap_frac_r);
  assign adv_w  = gain_w[GAIN_W-1:TIME_FRAC_BITS];
  assign next_w = DIV_W'(snap_pos_r) + DIV_W'(adv_w);

  // One restoring remainder step
  assign shift_w = {rem_r, dvd_r[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.prep) begin
      start_r     <= start_w;
      end_r       <= end_w;
      span_r      <= SPAN_W'(end_w) - SPAN_W'(start_w) + SPAN_W'(1);
      snap_pos_r  <= outside_w ? FRAME_BITS'(start_w) : frame_position_r;
      snap_frac_r <= outside_w ? '0 : frame_fraction_r;
      prod_r      <= PROD_W'(req_r.elapsed) * PROD_W'(fps_w);
    end
    if (cmd.sum) begin
      next_r     <= next_w;
      new_frac_r <= gain_w[TIME_FRAC_BITS-1:0];
      adv_zero_r <= (adv_w == '0);
      over_r     <= (next_w > DIV_W'(end_r));
    end
    if (cmd.div_load) begin
      dvd_r <= next_r - DIV_W'(start_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      if (shift_w >= (SPAN_W + 1)'(span_r)) begin
        rem_r <= SPAN_W'(shift_w - (SPAN_W + 1)'(span_r));
      end else begin
        rem_r <= shift_w[SPAN_W-1:0];
      end
    end
  end

  // Settle the command's effect on the playback state
  always_comb begin
    frame_position_nxt       = frame_position_r;
    running_nxt              = running_r;
    frame_fraction_nxt       = frame_fraction_r;
    out_data_nxt.apply_frame = 1'b0;
    out_data_nxt.changed     = 1'b0;
    scrub_w = (req_r.target_frame > loop_start_r) ? req_r.target_frame : loop_start_r;
    if (!over_r) begin
      res_w = next_r;
    end else if (loop_en_r) begin
      res_w = DIV_W'(start_r) + DIV_W'(rem_r);
    end else begin
      res_w = DIV_W'(end_r);
    end
    unique case (req_r.func)
      FN_TICK: begin
        if (running_r) begin
          frame_fraction_nxt = new_frac_r;
          if (adv_zero_r) begin
            frame_position_nxt = snap_pos_r;
          end else begin
            frame_position_nxt       = res_w[FRAME_BITS-1:0];
            running_nxt              = !(over_r && !loop_en_r);
            out_data_nxt.apply_frame = 1'b1;
            out_data_nxt.changed     = 1'b1;
          end
        end
      end
      FN_PLAY: begin
        running_nxt              = 1'b1;
        frame_fraction_nxt       = '0;
        out_data_nxt.apply_frame = 1'b1;
        out_data_nxt.changed     = 1'b1;
      end
      FN_PAUSE: begin
        running_nxt          = 1'b0;
        out_data_nxt.changed = 1'b1;
      end
      FN_STOP: begin
        running_nxt              = 1'b0;
        frame_fraction_nxt       = '0;
        frame_position_nxt       = FRAME_BITS'(loop_start_r);
        out_data_nxt.apply_frame = 1'b1;
        out_data_nxt.changed     = 1'b1;
      end
      FN_SCRUB: begin
        frame_position_nxt       = FRAME_BITS'(scrub_w);
        out_data_nxt.apply_frame = 1'b1;
        out_data_nxt.changed     = 1'b1;
      end
      default: begin
      end
    endcase
    out_data_nxt.frame_now  = FRM_W'(frame_position_nxt);
    out_data_nxt.is_playing = running_nxt;
  end

  // Hold configuration, playback state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fps_r            <= FPS_RESET;
      loop_start_r     <= '0;
      loop_end_r       <= LOOP_END_RESET;
      fixed_len_r      <= '0;
      loop_en_r        <= 1'b0;
      frame_position_r <= '0;
      running_r        <= 1'b0;
      frame_fraction_r <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_FPS:        fps_r        <= cfg_data[FPS_W-1:0];
          REG_LOOP_START: loop_start_r <= cfg_data[FRM_W-1:0];
          REG_LOOP_END:   loop_end_r   <= cfg_data[LEND_W-1:0];
          REG_FIXED_LEN:  fixed_len_r  <= cfg_data[FRM_W-1:0];
          REG_LOOP_EN:    loop_en_r    <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        frame_position_r <= frame_position_nxt;
        running_r        <= running_nxt;
        frame_fraction_r <= frame_fraction_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.tick_run = tick_run_w;
  assign sts.need_div = over_r && loop_en_r && !adv_zero_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("result committed over an unread result");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> (rem_r < span_r))
    else $error("remainder not below region span");

  a_wrap_in_region: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && tick_run_w && !adv_zero_r && over_r && loop_en_r)
      |=> (DIV_W'(frame_position_r) <= DIV_W'($past(end_r))))
    else $error("wrapped frame beyond region end");

endmodule
`default_nettype wire

/* design/loop_region_playback_clock_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake            Payload
// in_      in   in_valid / in_stall    in_req_t: func, elapsed, device_frames, target_frame
// out_     out  out_valid / out_stall  out_req_t: frame_now, is_playing, apply_frame, changed
// cfg_     in   cfg_wr_en              cfg_index, cfg_data (write only)
//
// One request at a time. Play, pause, stop, scrub, unknown commands and ticks
// while paused go from load straight to commit; a running tick also sums the gained
// time and checks for a wrap, and a wrap in a looped region runs the one-bit-a-cycle remainder unit.
// Synchronous active-low reset restores register defaults and paused state.
// A new request is taken while an earlier result waits in the output register;
// the next result is held back until out_stall drops.
module loop_region_playback_clock_core #(
  parameter int FRAME_BITS     = 20,
  parameter int TIME_FRAC_BITS = 24
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  lrpc_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output lrpc_pkg::out_req_t                  out_data,
  input  wire                                 cfg_wr_en,
  input  wire  [lrpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [lrpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lrpc_pkg::*;

  // Width of frame comparisons and of the remainder dividend
  localparam int CMP_W = (FRAME_BITS > FRM_W) ? FRAME_BITS : FRM_W;
  localparam int ADV_W = GAIN_W - TIME_FRAC_BITS;
  localparam int DIV_W = ((CMP_W > ADV_W) ? CMP_W : ADV_W) + 1;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  lrpc_ctrl #(
    .DIV_STEPS (DIV_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrpc_dpath #(
    .FRAME_BITS     (FRAME_BITS),
    .TIME_FRAC_BITS (TIME_FRAC_BITS),
    .DIV_W          (DIV_W)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire
